// ----- design/usmg_pkg.sv -----
// ============================================================================
// usmg_pkg
// Shared widths, register codes and the quarter-wave sine table function
// used by the UV-sphere mesh generator.
// ============================================================================
package usmg_pkg;

  localparam int MAX_RINGS_C       = 256;
  localparam int MAX_SEGMENTS_C    = 256;
  localparam int TRIG_TABLE_SIZE_C = 1024;

  localparam int CNT_W    = 9;   // ring and segment counts, indices
  localparam int RAD_W    = 16;
  localparam int POS_W    = 17;
  localparam int SHADE_W  = 17;
  localparam int CORNER_W = 16;
  localparam int DIVD_W   = 17;  // dividend and quotient width
  localparam int DIVS_W   = 10;  // divisor width, holds twice the ring count
  localparam int TRIG_W   = 18;  // signed table value, +/- 65536

  localparam logic [SHADE_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [CNT_W-1:0] RING_COUNT_RST    = 9'd16;
  localparam logic [CNT_W-1:0] SEGMENT_COUNT_RST = 9'd16;
  localparam logic [RAD_W-1:0] SPHERE_RADIUS_RST = 16'd256;

  typedef enum logic [1:0] {
    CFG_RING_COUNT    = 2'd0,
    CFG_SEGMENT_COUNT = 2'd1,
    CFG_SPHERE_RADIUS = 2'd2
  } usmg_cfg_idx_t;

  // Quotient and remainder of a running fraction n*K/D.
  typedef struct packed {
    logic [DIVD_W-1:0] quo;
    logic [DIVS_W-1:0] rem;
  } usmg_acc_t;

  localparam longint unsigned K1 = 64'd1686629713;
  localparam longint unsigned K3 = 64'd693598668;
  localparam longint unsigned K5 = 64'd85569306;
  localparam longint unsigned K7 = 64'd5026996;
  localparam longint unsigned K9 = 64'd172272;

  // Quarter-wave sine entry r of a table of 2**lg_size steps, Q16.
  function automatic logic [16:0] rom_entry(input int r, input int lg_size);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned b;
    longint unsigned f;
    t  = longint'(r) << (30 - lg_size);
    t2 = (t * t) >> 30;
    b  = K7 - ((t2 * K9) >> 30);
    b  = K5 - ((t2 * b) >> 30);
    b  = K3 - ((t2 * b) >> 30);
    b  = K1 - ((t2 * b) >> 30);
    f  = (t * b) >> 30;
    f  = (f + 64'd8192) >> 14;
    if (f > 64'd65536) f = 64'd65536;
    return f[16:0];
  endfunction

endpackage

// ----- design/usmg_if.sv -----
// ============================================================================
// usmg_if
// Valid/ready channels of the mesh generator: tick requests in, mesh items out.
// ============================================================================
interface usmg_tick_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface usmg_item_if import usmg_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       item_kind;
  logic signed [POS_W-1:0]    pos_x;
  logic signed [POS_W-1:0]    pos_y;
  logic signed [POS_W-1:0]    pos_z;
  logic        [SHADE_W-1:0]  shade_ring;
  logic        [SHADE_W-1:0]  shade_column;
  logic        [CORNER_W-1:0] corner_first;
  logic        [CORNER_W-1:0] corner_second;
  logic        [CORNER_W-1:0] corner_third;
  logic                       last_item;
  modport source (output valid, output item_kind, output pos_x, output pos_y, output pos_z,
                  output shade_ring, output shade_column, output corner_first,
                  output corner_second, output corner_third, output last_item,
                  input ready);
  modport sink (input valid, input item_kind, input pos_x, input pos_y, input pos_z,
                input shade_ring, input shade_column, input corner_first,
                input corner_second, input corner_third, input last_item,
                output ready);
endinterface

// ----- design/usmg_divider.sv -----
// ============================================================================
// usmg_divider
// Restoring divider, one quotient bit per cycle, used at the start of a run.
// ============================================================================
module usmg_divider import usmg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient,
  output logic [DIVS_W-1:0] remainder
);

  localparam int CW = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] rem_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIVS_W:0]   shifted;
  logic [DIVS_W+1:0] diff;

  assign shifted = {rem_r, quo_r[DIVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        cnt_r  <= CW'(DIVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!diff[DIVS_W+1]) begin
          rem_r <= diff[DIVS_W-1:0];
          quo_r <= {quo_r[DIVD_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[DIVS_W-1:0];
          quo_r <= {quo_r[DIVD_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- design/usmg_trig_rom.sv -----
// ============================================================================
// usmg_trig_rom
// Sine/cosine lookup from a quarter-wave table with registered read.
// ============================================================================
module usmg_trig_rom import usmg_pkg::*; #(
  parameter int TABLE_SIZE = TRIG_TABLE_SIZE_C
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [$clog2(TABLE_SIZE)-1:0]    phase,
  input  logic                             is_cos,
  output logic signed [TRIG_W-1:0]         value
);

  localparam int PW    = $clog2(TABLE_SIZE);
  localparam int DEPTH = TABLE_SIZE + 1;

  logic [16:0]   tab [DEPTH];
  logic [PW+1:0] quarter;
  logic [PW-1:0] r;
  logic [PW:0]   idx;
  logic [16:0]   mag_r;
  logic          neg_r;

  for (genvar g = 0; g < DEPTH; g++) begin : g_tab
    assign tab[g] = rom_entry(g, PW);
  end

  // Cosine is the sine a quarter turn ahead; the sum wraps at a full turn.
  assign quarter = {phase, 2'b00} + (is_cos ? (PW+2)'(TABLE_SIZE) : '0);
  assign r       = quarter[PW-1:0];
  assign idx     = quarter[PW] ? (PW+1)'(TABLE_SIZE) - {1'b0, r} : {1'b0, r};

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= tab[idx];
      neg_r <= quarter[PW+1];
    end
  end

  assign value = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});

endmodule

// ----- design/usmg_mul.sv -----
// ============================================================================
// usmg_mul
// Shared sign-magnitude Q16 multiplier with rounding, one registered stage.
// ============================================================================
module usmg_mul import usmg_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [TRIG_W-1:0]  a,
  input  logic signed [TRIG_W-1:0]  s,
  output logic signed [POS_W-1:0]   result
);

  logic [TRIG_W-1:0] abs_a;
  logic [TRIG_W-1:0] abs_s;
  logic [33:0]       prod_r;
  logic              neg_r;
  logic [34:0]       rounded;
  logic [16:0]       mag;

  assign abs_a = a[TRIG_W-1] ? -a : a;
  assign abs_s = s[TRIG_W-1] ? -s : s;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= abs_a[16:0] * abs_s[16:0];
      neg_r  <= a[TRIG_W-1] ^ s[TRIG_W-1];
    end
  end

  assign rounded = {1'b0, prod_r} + 35'd32768;
  assign mag     = rounded[32:16];
  assign result  = neg_r ? -$signed(mag) : $signed(mag);

endmodule

// ----- design/uv_sphere_mesh_generator.sv -----
// ============================================================================
// uv_sphere_mesh_generator
// UV-sphere tessellator: at most one mesh item (vertex or triangle) per tick request.
// ============================================================================
// Each tick request produces at most one mesh item. A restart request first
// runs four divisions on a bit-serial divider to set up the running phase and
// shade fractions, and then emits its north pole. For a ring vertex, four
// table reads and four products share one registered table port and one
// multiplier in a six-step sequence. Poles and triangles are written to the
// output register from the item state once that register is free. The block
// is ready for the next request in the cycle after a result is written.
// The block is not ready while a request is being worked on; a finished item
// waits in the output register while the next request is taken, and a result
// that is still waiting there holds up the one behind it. The table size must
// be a power of two.
module uv_sphere_mesh_generator import usmg_pkg::*; #(
  parameter int MAX_RINGS       = MAX_RINGS_C,
  parameter int MAX_SEGMENTS    = MAX_SEGMENTS_C,
  parameter int TRIG_TABLE_SIZE = TRIG_TABLE_SIZE_C
) (
  input  logic        clk,
  input  logic        rst_n,
  usmg_tick_if.sink   in_tick,
  usmg_item_if.source out_item,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int PW = $clog2(TRIG_TABLE_SIZE);

  typedef enum logic [3:0] {
    ST_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_ITEM,
    ST_V0, ST_V1, ST_V2, ST_V3, ST_V4, ST_V5
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_NORTH, PH_RING, PH_SOUTH, PH_TOP, PH_BAND, PH_BOTTOM, PH_DONE
  } phase_t;

  state_t              state_r;
  phase_t              phase_r;
  logic [CNT_W-1:0]    reg_rings_r, reg_segs_r;
  logic [RAD_W-1:0]    reg_radius_r;
  logic [CNT_W-1:0]    rows_r, cols_r;
  logic [RAD_W-1:0]    radius_r;
  logic [CNT_W-1:0]    ring_r, col_r;
  logic                half_r;
  logic [CORNER_W-1:0] base_r;
  logic [1:0]          div_sel_r;

  // Per-run step sizes: phase and shade advance per column and per ring.
  usmg_acc_t step_pc_r, step_sc_r, step_pr_r, step_sr_r;
  usmg_acc_t acc_pc_r, acc_sc_r, acc_pr_r, acc_sr_r;

  logic signed [POS_W-1:0] m_r, x_r, y_r;

  logic                       out_valid_r;
  logic                       out_kind_r;
  logic signed [POS_W-1:0]    out_x_r, out_y_r, out_z_r;
  logic        [SHADE_W-1:0]  out_sr_r, out_sc_r;
  logic        [CORNER_W-1:0] out_c1_r, out_c2_r, out_c3_r;
  logic                       out_last_r;

  logic cfg_wr;
  logic out_free;
  logic out_load;
  logic in_take;

  logic              div_start, div_done;
  logic [DIVD_W-1:0] div_dividend, div_quo;
  logic [DIVS_W-1:0] div_divisor, div_rem;

  logic                     rom_en, rom_cos;
  logic [PW-1:0]            rom_phase;
  logic signed [TRIG_W-1:0] trig;

  logic                     mul_en;
  logic signed [TRIG_W-1:0] mul_a;
  logic signed [POS_W-1:0]  mul_res;

  logic [CNT_W-1:0]    col_n;
  logic                col_wrap;
  logic [CORNER_W-1:0] j16, n16, cols16;
  logic [CNT_W+1:0]    rings_clamp, segs_clamp;

  function automatic usmg_acc_t acc_step(input usmg_acc_t acc, input usmg_acc_t step,
                                          input logic [DIVS_W-1:0] modulus);
    usmg_acc_t   res;
    logic [DIVS_W:0] sum;
    sum = {1'b0, acc.rem} + {1'b0, step.rem};
    if (sum >= {1'b0, modulus}) begin
      res.rem = DIVS_W'(sum - {1'b0, modulus});
      res.quo = acc.quo + step.quo + 1'b1;
    end else begin
      res.rem = sum[DIVS_W-1:0];
      res.quo = acc.quo + step.quo;
    end
    return res;
  endfunction

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[3:2])
      CFG_RING_COUNT:    cfg_prdata = {23'd0, reg_rings_r};
      CFG_SEGMENT_COUNT: cfg_prdata = {23'd0, reg_segs_r};
      CFG_SPHERE_RADIUS: cfg_prdata = {16'd0, reg_radius_r};
      default:           cfg_prdata = '0;
    endcase
  end

  assign rings_clamp = ({2'b00, reg_rings_r} < 11'd2) ? 11'd2 :
                       ({2'b00, reg_rings_r} > 11'(MAX_RINGS)) ? 11'(MAX_RINGS) :
                       {2'b00, reg_rings_r};
  assign segs_clamp  = ({2'b00, reg_segs_r} < 11'd3) ? 11'd3 :
                       ({2'b00, reg_segs_r} > 11'(MAX_SEGMENTS)) ? 11'(MAX_SEGMENTS) :
                       {2'b00, reg_segs_r};

  assign in_tick.ready = (state_r == ST_WAIT);
  assign in_take       = in_tick.valid && (state_r == ST_WAIT);
  assign out_free      = !out_valid_r || out_item.ready;
  assign out_load      = out_free &&
                         (((state_r == ST_ITEM) &&
                           (phase_r inside {PH_NORTH, PH_SOUTH, PH_TOP, PH_BAND, PH_BOTTOM})) ||
                          (state_r == ST_V5));

  assign col_wrap = (col_r + 1'b1 == cols_r);
  assign col_n    = col_wrap ? '0 : col_r + 1'b1;
  assign j16      = CORNER_W'(col_r);
  assign n16      = CORNER_W'(col_n);
  assign cols16   = CORNER_W'(cols_r);

  // Divider operands, in the order the step sizes are filled.
  assign div_start = (state_r == ST_DIV_GO);
  always_comb begin
    case (div_sel_r)
      2'd0: begin
        div_dividend = DIVD_W'(TRIG_TABLE_SIZE);
        div_divisor  = DIVS_W'(cols_r);
      end
      2'd1: begin
        div_dividend = DIVD_W'(ONE_Q16);
        div_divisor  = DIVS_W'(cols_r);
      end
      2'd2: begin
        div_dividend = DIVD_W'(TRIG_TABLE_SIZE);
        div_divisor  = {rows_r, 1'b0};
      end
      default: begin
        div_dividend = DIVD_W'(ONE_Q16);
        div_divisor  = DIVS_W'(rows_r);
      end
    endcase
  end

  usmg_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Table reads: sin(pr), cos(pr), cos(pc), sin(pc), one per step.
  assign rom_en    = (state_r == ST_V0) || (state_r == ST_V1) ||
                     (state_r == ST_V2) || (state_r == ST_V3);
  assign rom_cos   = (state_r == ST_V1) || (state_r == ST_V2);
  assign rom_phase = ((state_r == ST_V0) || (state_r == ST_V1)) ? acc_pr_r.quo[PW-1:0]
                                                                : acc_pc_r.quo[PW-1:0];

  usmg_trig_rom #(.TABLE_SIZE(TRIG_TABLE_SIZE)) u_rom (
    .clk    (clk),
    .en     (rom_en),
    .phase  (rom_phase),
    .is_cos (rom_cos),
    .value  (trig)
  );

  assign mul_en = (state_r == ST_V1) || (state_r == ST_V2) ||
                  (state_r == ST_V3) || (state_r == ST_V4);
  assign mul_a  = ((state_r == ST_V1) || (state_r == ST_V2)) ?
                  $signed({2'b00, radius_r}) : TRIG_W'(m_r);

  usmg_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .s      (trig),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_WAIT;
      phase_r      <= PH_IDLE;
      ring_r       <= '0;
      col_r        <= '0;
      half_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      reg_rings_r  <= RING_COUNT_RST;
      reg_segs_r   <= SEGMENT_COUNT_RST;
      reg_radius_r <= SPHERE_RADIUS_RST;
      rows_r       <= RING_COUNT_RST;
      cols_r       <= SEGMENT_COUNT_RST;
      radius_r     <= SPHERE_RADIUS_RST;
      div_sel_r    <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          CFG_RING_COUNT:    reg_rings_r  <= cfg_pwdata[CNT_W-1:0];
          CFG_SEGMENT_COUNT: reg_segs_r   <= cfg_pwdata[CNT_W-1:0];
          CFG_SPHERE_RADIUS: reg_radius_r <= cfg_pwdata[RAD_W-1:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_item.ready) out_valid_r <= 1'b0;

      case (state_r)
        ST_WAIT: begin
          if (in_take) begin
            if (in_tick.restart) begin
              rows_r    <= rings_clamp[CNT_W-1:0];
              cols_r    <= segs_clamp[CNT_W-1:0];
              radius_r  <= reg_radius_r;
              phase_r   <= PH_NORTH;
              ring_r    <= '0;
              col_r     <= '0;
              half_r    <= 1'b0;
              base_r    <= CORNER_W'(1);
              div_sel_r <= '0;
              state_r   <= ST_DIV_GO;
            end else begin
              state_r <= ST_ITEM;
            end
          end
        end
        ST_DIV_GO: state_r <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_done) begin
            case (div_sel_r)
              2'd0:    step_pc_r <= '{quo: div_quo, rem: div_rem};
              2'd1:    step_sc_r <= '{quo: div_quo, rem: div_rem};
              2'd2:    step_pr_r <= '{quo: div_quo, rem: div_rem};
              default: step_sr_r <= '{quo: div_quo, rem: div_rem};
            endcase
            if (div_sel_r == 2'd3) begin
              acc_pc_r <= '0;
              acc_sc_r <= '0;
              acc_pr_r <= step_pr_r;
              acc_sr_r <= '0;
              state_r  <= ST_ITEM;
            end else begin
              div_sel_r <= div_sel_r + 1'b1;
              state_r   <= ST_DIV_GO;
            end
          end
        end
        ST_ITEM: begin
          case (phase_r)
            PH_RING: state_r <= ST_V0;
            PH_NORTH, PH_SOUTH, PH_TOP, PH_BAND, PH_BOTTOM: begin
              if (out_free) begin
                out_last_r  <= (phase_r == PH_BOTTOM) && col_wrap;
                state_r     <= ST_WAIT;
                if ((phase_r == PH_NORTH) || (phase_r == PH_SOUTH)) begin
                  out_kind_r <= 1'b0;
                  out_x_r    <= '0;
                  out_z_r    <= '0;
                  out_y_r    <= (phase_r == PH_NORTH) ? $signed({1'b0, radius_r})
                                                      : -$signed({1'b0, radius_r});
                  out_sr_r   <= ONE_Q16;
                  out_sc_r   <= ONE_Q16;
                  out_c1_r   <= '0;
                  out_c2_r   <= '0;
                  out_c3_r   <= '0;
                  col_r      <= '0;
                  phase_r    <= (phase_r == PH_NORTH) ? PH_RING : PH_TOP;
                end else begin
                  out_kind_r <= 1'b1;
                  out_x_r    <= '0;
                  out_y_r    <= '0;
                  out_z_r    <= '0;
                  out_sr_r   <= '0;
                  out_sc_r   <= '0;
                  // The first half of a quad stays on the same column.
                  col_r      <= ((phase_r == PH_BAND) && !half_r) ? col_r : col_n;
                  case (phase_r)
                    PH_TOP: begin
                      out_c1_r <= '0;
                      out_c2_r <= CORNER_W'(1) + n16;
                      out_c3_r <= CORNER_W'(1) + j16;
                      if (col_wrap) begin
                        ring_r  <= '0;
                        half_r  <= 1'b0;
                        base_r  <= CORNER_W'(1);
                        phase_r <= (rows_r > CNT_W'(2)) ? PH_BAND : PH_BOTTOM;
                      end
                    end
                    PH_BAND: begin
                      out_c1_r <= base_r + j16;
                      if (!half_r) begin
                        out_c2_r <= base_r + cols16 + j16;
                        out_c3_r <= base_r + cols16 + n16;
                        half_r   <= 1'b1;
                      end else begin
                        out_c2_r <= base_r + cols16 + n16;
                        out_c3_r <= base_r + n16;
                        half_r   <= 1'b0;
                        if (col_wrap) begin
                          ring_r <= ring_r + 1'b1;
                          base_r <= base_r + cols16;
                          if (ring_r + 1'b1 == rows_r - CNT_W'(2)) phase_r <= PH_BOTTOM;
                        end
                      end
                    end
                    default: begin
                      out_c1_r   <= base_r + j16;
                      out_c2_r   <= base_r + cols16;
                      out_c3_r   <= base_r + n16;
                      if (col_wrap) phase_r <= PH_DONE;
                    end
                  endcase
                end
              end
            end
            default: state_r <= ST_WAIT;
          endcase
        end
        ST_V0: state_r <= ST_V1;
        ST_V1: state_r <= ST_V2;
        ST_V2: begin
          m_r     <= mul_res;
          state_r <= ST_V3;
        end
        ST_V3: begin
          y_r     <= mul_res;
          state_r <= ST_V4;
        end
        ST_V4: begin
          x_r     <= mul_res;
          state_r <= ST_V5;
        end
        ST_V5: begin
          if (out_free) begin
            out_kind_r  <= 1'b0;
            out_x_r     <= x_r;
            out_y_r     <= y_r;
            out_z_r     <= mul_res;
            out_sr_r    <= acc_sr_r.quo;
            out_sc_r    <= acc_sc_r.quo;
            out_c1_r    <= '0;
            out_c2_r    <= '0;
            out_c3_r    <= '0;
            out_last_r  <= 1'b0;
            col_r       <= col_n;
            if (col_wrap) begin
              acc_pc_r <= '0;
              acc_sc_r <= '0;
              acc_pr_r <= acc_step(acc_pr_r, step_pr_r, {rows_r, 1'b0});
              acc_sr_r <= acc_step(acc_sr_r, step_sr_r, DIVS_W'(rows_r));
              ring_r   <= ring_r + 1'b1;
              base_r   <= base_r + cols16;
              if (ring_r + 1'b1 == rows_r - CNT_W'(1)) phase_r <= PH_SOUTH;
            end else begin
              acc_pc_r <= acc_step(acc_pc_r, step_pc_r, DIVS_W'(cols_r));
              acc_sc_r <= acc_step(acc_sc_r, step_sc_r, DIVS_W'(cols_r));
            end
            state_r <= ST_WAIT;
          end
        end
        default: state_r <= ST_WAIT;
      endcase
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.item_kind     = out_kind_r;
  assign out_item.pos_x         = out_x_r;
  assign out_item.pos_y         = out_y_r;
  assign out_item.pos_z         = out_z_r;
  assign out_item.shade_ring    = out_sr_r;
  assign out_item.shade_column  = out_sc_r;
  assign out_item.corner_first  = out_c1_r;
  assign out_item.corner_second = out_c2_r;
  assign out_item.corner_third  = out_c3_r;
  assign out_item.last_item     = out_last_r;

endmodule

// ----- design/usmg_checker.sv -----
// ============================================================================
// usmg_checker
// Port-level checks of the mesh generator, bound to the top level.
// ============================================================================
module usmg_checker import usmg_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                item_kind,
  input logic [POS_W-1:0]    pos_x,
  input logic [POS_W-1:0]    pos_y,
  input logic [POS_W-1:0]    pos_z,
  input logic [SHADE_W-1:0]  shade_ring,
  input logic [SHADE_W-1:0]  shade_column,
  input logic [CORNER_W-1:0] corner_first,
  input logic [CORNER_W-1:0] corner_second,
  input logic [CORNER_W-1:0] corner_third,
  input logic                last_item
);

  // A request being worked on blocks the next one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_vertex_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !item_kind) |-> (corner_first == '0 && corner_second == '0 &&
                                   corner_third == '0 && !last_item))
    else $error("vertex carries triangle fields");

  a_tri_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && item_kind) |-> (pos_x == '0 && pos_y == '0 && pos_z == '0 &&
                                  shade_ring == '0 && shade_column == '0))
    else $error("triangle carries vertex fields");

endmodule

bind uv_sphere_mesh_generator usmg_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_tick.valid),
  .in_ready      (in_tick.ready),
  .out_valid     (out_item.valid),
  .out_ready     (out_item.ready),
  .item_kind     (out_item.item_kind),
  .pos_x         (out_item.pos_x),
  .pos_y         (out_item.pos_y),
  .pos_z         (out_item.pos_z),
  .shade_ring    (out_item.shade_ring),
  .shade_column  (out_item.shade_column),
  .corner_first  (out_item.corner_first),
  .corner_second (out_item.corner_second),
  .corner_third  (out_item.corner_third),
  .last_item     (out_item.last_item)
);
